FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with active-low reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/slbcf_pkg.sv
// ----------------------------------------------------------------------------
// slbcf_pkg
// Shared types and constants of the serial line buffer command FIFO.
// ----------------------------------------------------------------------------
package slbcf_pkg;

    localparam int CMD_SIZE_DEF   = 32;
    localparam int FIFO_SLOTS_DEF = 4;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_CMD   = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NL,
        ST_RD
    } slbcf_state_t;

endpackage

FILE: rtl/core/serial_line_buffer_command_fifo_top.sv
// ----------------------------------------------------------------------------
// serial_line_buffer_command_fifo_top
// Collects received characters into command lines held in a ring of line
// slots and reads out the oldest line on request.
//
//   channel | dir | tdata          | tuser           | tlast
//   s_*     | in  | [7:0] rx_byte  | [0] opcode      | -
//   m_*     | out | [7:0] data_byte| [1:0] kind      | last
//
// A received byte is echoed; a carriage return also queues a newline echo.
// A read performs one line-store read per byte, paced by the single read
// port. After reset a clearing pass writes zero to
// FIFO_SLOTS * 2**clog2(CMD_SIZE) entries, one per cycle, with s_tready low.
// Output stalls hold the sequencer; one transfer waits in the output
// register.
// ----------------------------------------------------------------------------
module serial_line_buffer_command_fifo_top
    import slbcf_pkg::*;
#(
    parameter int CMD_SIZE   = CMD_SIZE_DEF,
    parameter int FIFO_SLOTS = FIFO_SLOTS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic [0:0] s_tuser,   // [0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [1:0] m_tuser,   // [1:0] kind
    output logic       m_tlast
);

    localparam int PW        = $clog2(CMD_SIZE);
    localparam int SW        = $clog2(FIFO_SLOTS);
    localparam int AW        = PW + SW;
    localparam int MEM_DEPTH = FIFO_SLOTS << PW;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    slbcf_ctrl #(
        .CMD_SIZE   (CMD_SIZE),
        .FIFO_SLOTS (FIFO_SLOTS),
        .PW         (PW),
        .SW         (SW),
        .AW         (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    slbcf_line_ram #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

FILE: rtl/core/slbcf_line_ram.sv
// ----------------------------------------------------------------------------
// slbcf_line_ram
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module slbcf_line_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/slbcf_ctrl.sv
// ----------------------------------------------------------------------------
// slbcf_ctrl
// Slot pointers, line position, clearing sweep, read-out sequencer and
// output register.
// ----------------------------------------------------------------------------
module slbcf_ctrl
    import slbcf_pkg::*;
#(
    parameter int CMD_SIZE   = CMD_SIZE_DEF,
    parameter int FIFO_SLOTS = FIFO_SLOTS_DEF,
    parameter int PW         = $clog2(CMD_SIZE),
    parameter int SW         = $clog2(FIFO_SLOTS),
    parameter int AW         = PW + SW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic [0:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    input  logic [7:0]    mem_rdata
);

    localparam int MEM_DEPTH = FIFO_SLOTS << PW;

    slbcf_state_t  state_reg, state_next;
    logic [SW-1:0] ws_reg, ws_next;
    logic [SW-1:0] rs_reg, rs_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [AW-1:0] clr_reg, clr_next;

    logic          ovalid_reg, ovalid_next;
    logic [7:0]    odata_reg, odata_next;
    logic [1:0]    okind_reg, okind_next;
    logic          olast_reg, olast_next;

    logic          out_free;
    logic          accept;
    logic [SW-1:0] ws_inc;
    logic [SW-1:0] rs_inc;

    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign ws_inc   = (ws_reg == SW'(FIFO_SLOTS - 1)) ? '0 : ws_reg + SW'(1);
    assign rs_inc   = (rs_reg == SW'(FIFO_SLOTS - 1)) ? '0 : rs_reg + SW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            ws_reg     <= '0;
            rs_reg     <= '0;
            pos_reg    <= '0;
            idx_reg    <= '0;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ws_reg     <= ws_next;
            rs_reg     <= rs_next;
            pos_reg    <= pos_next;
            idx_reg    <= idx_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        odata_reg <= odata_next;
        okind_reg <= okind_next;
        olast_reg <= olast_next;
    end

    always_comb begin
        state_next  = state_reg;
        ws_next     = ws_reg;
        rs_next     = rs_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        clr_next    = clr_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        okind_next  = okind_reg;
        olast_next  = olast_reg;
        mem_we      = 1'b0;
        mem_waddr   = {ws_reg, pos_reg};
        mem_wdata   = s_tdata;
        mem_re      = 1'b0;
        mem_raddr   = {rs_reg, idx_reg};

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = CH_NUL;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(MEM_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    ovalid_next = 1'b1;
                    if (s_tuser[0] == OP_BYTE) begin
                        mem_we     = 1'b1;
                        odata_next = s_tdata;
                        okind_next = KIND_ECHO;
                        olast_next = 1'b1;
                        if (s_tdata == CH_CR) begin
                            mem_wdata  = CH_NUL;
                            olast_next = 1'b0;
                            pos_next   = '0;
                            state_next = ST_NL;
                            if (ws_inc != rs_reg) begin
                                ws_next = ws_inc;
                            end
                        end else if (s_tdata == CH_BS) begin
                            if (pos_reg != '0) begin
                                pos_next = pos_reg - PW'(1);
                            end
                        end else if (pos_reg == PW'(CMD_SIZE - 1)) begin
                            pos_next = '0;
                        end else begin
                            pos_next = pos_reg + PW'(1);
                        end
                    end else if (rs_reg == ws_reg) begin
                        odata_next = CH_NUL;
                        okind_next = KIND_EMPTY;
                        olast_next = 1'b1;
                    end else begin
                        ovalid_next = ovalid_reg && !m_tready;
                        mem_re      = 1'b1;
                        mem_raddr   = {rs_reg, {PW{1'b0}}};
                        idx_next    = '0;
                        state_next  = ST_RD;
                    end
                end
            end
            ST_NL: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    odata_next  = CH_NL;
                    okind_next  = KIND_ECHO;
                    olast_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_RD: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    odata_next  = mem_rdata;
                    okind_next  = KIND_CMD;
                    olast_next  = (idx_reg == PW'(CMD_SIZE - 1));
                    if (idx_reg == PW'(CMD_SIZE - 1)) begin
                        rs_next    = rs_inc;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next  = idx_reg + PW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = {rs_reg, idx_reg + PW'(1)};
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

endmodule

FILE: rtl/core/slbcf_checker.sv
// ----------------------------------------------------------------------------
// slbcf_checker
// Port-level checks of the command FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slbcf_checker
    import slbcf_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    logic        m_stall;
    logic        m_free;
    logic [10:0] m_bus;
    logic        empty_seen;
    logic        empty_ok;
    logic        echo_seen;
    logic        echo_ok;

    assign m_stall    = m_tvalid && !m_tready;
    assign m_free     = !m_tvalid || m_tready;
    assign m_bus      = {m_tuser, m_tdata, m_tlast};
    assign empty_seen = m_tvalid && (m_tuser == KIND_EMPTY);
    assign empty_ok   = m_tlast && (m_tdata == CH_NUL);
    assign echo_seen  = m_tvalid && (m_tuser == KIND_ECHO);
    assign echo_ok    = m_tlast == (m_tdata != CH_CR);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_stall, m_tvalid && $stable(m_bus), "output moved")

    `ASSERT_IMPLIES(a_empty_form, aclk, aresetn, empty_seen, empty_ok, "ring empty malformed")

    `ASSERT_IMPLIES(a_echo_last, aclk, aresetn, echo_seen, echo_ok, "echo last flag wrong")

    `ASSERT_IMPLIES(a_in_gate, aclk, aresetn, s_tready, m_free, "input open while blocked")

endmodule

bind serial_line_buffer_command_fifo_top slbcf_checker u_slbcf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
